// ===== src/hutw_pkg.sv =====
package hutw_pkg;

  localparam int IDX_W       = 10;
  localparam int TABLE_DEPTH = 1 << IDX_W;
  localparam int WORD_W      = 16;
  localparam int VAL_W       = 16;
  localparam int CNT_W       = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [0:0] {
    ACT_LOAD   = 1'b0,
    ACT_DECODE = 1'b1
  } action_t;

  typedef struct packed {
    action_t          act;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] val;
    logic             internal;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0] nbits;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FLUSH
  } back_state_t;

endpackage

// ===== src/hutw_front.sv =====
module hutw_front import hutw_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  output logic                 q_valid,
  output cmd_t                 q_cmd,
  input  logic                 q_pop
);

  cmd_t               queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               push;
  logic               pop;
  cmd_t               cmd_in;
  logic [CNT_W-1:0]   nbits_raw;

  // classify and clamp the request
  always_comb begin
    nbits_raw       = in_tdata[47:43];
    cmd_in.act      = action_t'(in_tuser);
    cmd_in.idx      = in_tdata[IDX_W-1:0];
    cmd_in.val      = in_tdata[25:10];
    cmd_in.internal = in_tdata[26];
    cmd_in.word     = in_tdata[42:27];
    cmd_in.nbits    = (nbits_raw > CNT_W'(WORD_W)) ? CNT_W'(WORD_W) : nbits_raw;
  end

  assign in_tready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (count_r != '0);
  assign q_cmd     = queue_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ===== src/hutw_back.sv =====
module hutw_back import hutw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [VAL_W:0]     table_mem [TABLE_DEPTH];
  logic [VAL_W:0]     rdata_r;

  back_state_t        state_r, state_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic [VAL_W-1:0]   cur_val_r, cur_val_nxt;
  logic               cur_int_r, cur_int_nxt;
  logic [VAL_W-1:0]   root_val_r, root_val_nxt;
  logic               root_int_r, root_int_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [CNT_W-1:0]   iss_left_r, iss_left_nxt;
  logic [CNT_W-1:0]   res_left_r, res_left_nxt;
  logic               held_v_r, held_v_nxt;
  logic [VAL_W-1:0]   held_val_r, held_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_last_r, out_last_nxt;

  logic               can_push;
  logic               mem_we;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [VAL_W:0]     addr_sum;
  logic               base_int;
  logic [VAL_W-1:0]   base_val;
  logic               next_int;
  logic [VAL_W-1:0]   next_val;
  logic               emit;
  logic [VAL_W-1:0]   emit_val;
  logic               push;
  logic [VAL_W-1:0]   push_val;
  logic               push_last;

  assign can_push   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_cmd.act == ACT_DECODE) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (res_left_r == '0) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!held_v_r || can_push) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    pos_nxt      = pos_r;
    cur_val_nxt  = cur_val_r;
    cur_int_nxt  = cur_int_r;
    root_val_nxt = root_val_r;
    root_int_nxt = root_int_r;
    pend_nxt     = pend_r;
    pend_idx_nxt = pend_idx_r;
    word_nxt     = word_r;
    iss_left_nxt = iss_left_r;
    res_left_nxt = res_left_r;
    held_v_nxt   = held_v_r;
    held_val_nxt = held_val_r;
    q_pop        = 1'b0;
    mem_we       = 1'b0;
    rd_en        = 1'b0;
    emit         = 1'b0;
    emit_val     = '0;
    push         = 1'b0;
    push_val     = held_val_r;
    push_last    = 1'b0;
    base_int     = (pos_r == '0) ? root_int_r : cur_int_r;
    base_val     = (pos_r == '0) ? root_val_r : cur_val_r;
    next_int     = 1'b0;
    next_val     = '0;
    addr_sum     = '0;
    rd_addr      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_cmd.act == ACT_LOAD) begin
            mem_we = 1'b1;
            if (q_cmd.idx == '0) begin
              root_val_nxt = q_cmd.val;
              root_int_nxt = q_cmd.internal;
            end
            if (q_cmd.idx == pos_r) begin
              cur_val_nxt = q_cmd.val;
              cur_int_nxt = q_cmd.internal;
            end
          end else begin
            word_nxt     = q_cmd.word;
            iss_left_nxt = q_cmd.nbits;
            res_left_nxt = q_cmd.nbits;
            pend_nxt     = 1'b0;
          end
        end
      end
      ST_WALK: begin
        if (res_left_r != '0 && can_push) begin
          // resolve one bit
          if (pend_r) begin
            res_left_nxt = res_left_r - 1'b1;
            pend_nxt     = 1'b0;
            if (rdata_r[VAL_W]) begin
              pos_nxt     = pend_idx_r;
              cur_val_nxt = rdata_r[VAL_W-1:0];
              cur_int_nxt = 1'b1;
            end else begin
              emit     = 1'b1;
              emit_val = rdata_r[VAL_W-1:0];
              pos_nxt  = '0;
            end
          end else if (!base_int) begin
            emit         = 1'b1;
            emit_val     = base_val;
            pos_nxt      = '0;
            res_left_nxt = res_left_r - 1'b1;
            iss_left_nxt = iss_left_r - 1'b1;
            word_nxt     = {word_r[WORD_W-2:0], 1'b0};
          end
          // start the table read for the following bit
          next_int = (pos_nxt == '0) ? root_int_r : cur_int_nxt;
          next_val = (pos_nxt == '0) ? root_val_r : cur_val_nxt;
          if (iss_left_nxt != '0 && next_int) begin
            addr_sum     = {1'b0, next_val} + (VAL_W + 1)'(word_nxt[WORD_W-1]);
            rd_addr      = addr_sum[IDX_W-1:0];
            rd_en        = 1'b1;
            pend_nxt     = 1'b1;
            pend_idx_nxt = rd_addr;
            iss_left_nxt = iss_left_nxt - 1'b1;
            word_nxt     = {word_nxt[WORD_W-2:0], 1'b0};
          end
          // symbols go out one behind so the final one can carry tlast
          if (emit) begin
            push         = held_v_r;
            held_v_nxt   = 1'b1;
            held_val_nxt = emit_val;
          end
        end
      end
      ST_FLUSH: begin
        if (held_v_r && can_push) begin
          push       = 1'b1;
          push_last  = 1'b1;
          held_v_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = push_val;
      out_last_nxt  = push_last;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      iss_left_r  <= '0;
      res_left_r  <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      iss_left_r  <= iss_left_nxt;
      res_left_r  <= res_left_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_val_r  <= cur_val_nxt;
    cur_int_r  <= cur_int_nxt;
    root_val_r <= root_val_nxt;
    root_int_r <= root_int_nxt;
    pend_idx_r <= pend_idx_nxt;
    word_r     <= word_nxt;
    held_val_r <= held_val_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  // code tree table
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[q_cmd.idx] <= {q_cmd.internal, q_cmd.val};
    end
    if (rd_en) begin
      rdata_r <= table_mem[rd_addr];
    end
  end

endmodule

// ===== src/huffman_table_walk_decoder_unit.sv =====
// Huffman decoder that walks a code tree held in a 1024-entry table. A request
// with tuser low writes one table entry (a leaf symbol, or the left child index
// of an internal node whose right child sits at the next index); a request with
// tuser high decodes the leading valid_bits of a 16-bit word, MSB first, and
// returns one result per symbol reached, tlast on the last symbol of that word.
// The walk position carries over between words, so a code may span words. A
// load is written while the decode engine stays idle; a word holds the engine
// through its walk and flush states, plus any output stall. Bits go one per
// cycle while the output does not stall, set by the registered table read that
// each bit needs before the next can pick its child. A four-deep request queue
// lets the input keep accepting while the engine works or the output stalls.
module huffman_table_walk_decoder_unit import hutw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // entry_index, entry_value, entry_internal, data_word, valid_bits
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // symbol
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  hutw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  hutw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== src/hutw_checker.sv =====
module hutw_checker import hutw_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  // reset empties the request queue
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("queue not empty after reset");

endmodule

bind huffman_table_walk_decoder_unit hutw_checker u_hutw_checker (.*);

// ===== bench/testbench.sv =====
module testbench;
  import hutw_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int VAL_LSB      = IDX_W;
  localparam int INT_BIT      = IDX_W + VAL_W;
  localparam int WORD_LSB     = INT_BIT + 1;
  localparam int NBITS_LSB    = WORD_LSB + WORD_W;

  typedef struct packed {
    logic [VAL_W-1:0] symbol;
    logic             last;
  } symbol_t;

  class huffman_scoreboard;
    logic [VAL_W-1:0] node_value [TABLE_DEPTH];
    logic             node_internal [TABLE_DEPTH];
    bit               written [TABLE_DEPTH];
    logic [IDX_W-1:0] walk_pos;
    symbol_t          symbol_q [$];
    int               errors;

    function new();
      walk_pos = '0;
      errors = 0;
      foreach (written[i]) written[i] = 1'b0;
    endfunction

    function int pending();
      return symbol_q.size();
    endfunction

    // true when decoding this word only reads entries that were written
    function bit walk_is_safe(logic [WORD_W-1:0] word, logic [CNT_W-1:0] nbits);
      logic [IDX_W-1:0] pos;
      int n;
      pos = walk_pos;
      n = int'(nbits);
      if (n > WORD_W) n = WORD_W;
      for (int k = 0; k < n; k++) begin
        if (!written[pos]) return 1'b0;
        if (node_internal[pos]) begin
          pos = IDX_W'(node_value[pos] + word[WORD_W-1-k]);
          if (!written[pos]) return 1'b0;
        end
        if (!node_internal[pos]) pos = '0;
      end
      return 1'b1;
    endfunction

    function void note_request(action_t act, logic [IN_DATA_W-1:0] data);
      logic [IDX_W-1:0] idx, pos;
      logic [WORD_W-1:0] word;
      int n;
      bit held;
      symbol_t sym;
      idx  = data[IDX_W-1:0];
      word = data[WORD_LSB +: WORD_W];
      n    = int'(data[NBITS_LSB +: CNT_W]);
      held = 1'b0;
      if (act == ACT_LOAD) begin
        node_value[idx]    = data[VAL_LSB +: VAL_W];
        node_internal[idx] = data[INT_BIT];
        written[idx]       = 1'b1;
        return;
      end
      if (n > WORD_W) n = WORD_W;
      pos = walk_pos;
      for (int k = 0; k < n; k++) begin
        if (node_internal[pos]) pos = IDX_W'(node_value[pos] + word[WORD_W-1-k]);
        if (!node_internal[pos]) begin
          if (held) symbol_q.push_back(sym);
          sym.symbol = node_value[pos];
          sym.last   = 1'b0;
          held = 1'b1;
          pos = '0;
        end
      end
      walk_pos = pos;
      if (held) begin
        sym.last = 1'b1;
        symbol_q.push_back(sym);
      end
    endfunction

    function void check_symbol(logic [VAL_W-1:0] symbol, logic last);
      symbol_t want;
      if (symbol_q.size() == 0) begin
        $error("symbol: expected none, actual %0d", $signed(symbol));
        errors++;
        return;
      end
      want = symbol_q.pop_front();
      if (symbol !== want.symbol) begin
        $error("symbol: expected %0d, actual %0d", $signed(want.symbol), $signed(symbol));
        errors++;
      end
      if (last !== want.last) begin
        $error("last_in_word: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  huffman_scoreboard sb;
  bit                idle_on = 1'b1;
  int                sent = 0;
  int                cycle_count = 0;
  logic [IDX_W-1:0]  pair_base;
  bit                have_pair = 1'b0;

  huffman_table_walk_decoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_symbol(out_tdata, out_tlast);
  end

  initial begin
    int stall;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  task automatic send_request(action_t act, logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val,
                              logic is_internal, logic [WORD_W-1:0] word,
                              logic [CNT_W-1:0] nbits);
    logic [IN_DATA_W-1:0] data;
    int gap;
    data = {nbits, word, is_internal, val, idx};
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= data;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_request(act, data);
    sent++;
  endtask

  task automatic load_entry(logic [IDX_W-1:0] idx, logic [VAL_W-1:0] val, logic is_internal);
    send_request(ACT_LOAD, idx, val, is_internal, WORD_W'($urandom), CNT_W'($urandom));
  endtask

  task automatic decode_word(logic [WORD_W-1:0] word, logic [CNT_W-1:0] nbits);
    if (sb.walk_is_safe(word, nbits))
      send_request(ACT_DECODE, IDX_W'($urandom), VAL_W'($urandom), 1'($urandom), word, nbits);
  endtask

  // hold off new requests until every expected symbol is out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // random complete code tree rooted at index 0, children in consecutive pairs
  task automatic build_tree(input int leaves);
    logic [IDX_W-1:0] slot_q [$];
    logic [IDX_W-1:0] node_idx [$];
    logic [VAL_W-1:0] node_val [$];
    logic [IDX_W-1:0] base, slot;
    int pick;
    slot_q.push_back('0);
    base = IDX_W'($urandom_range(1, TABLE_DEPTH - 2 * leaves));
    have_pair = leaves > 1;
    pair_base = base;
    while (slot_q.size() < leaves) begin
      pick = $urandom_range(0, slot_q.size() - 1);
      slot = slot_q[pick];
      slot_q.delete(pick);
      node_idx.push_back(slot);
      node_val.push_back({(VAL_W-IDX_W)'($urandom), base});
      slot_q.push_back(base);
      slot_q.push_back(base + 1'b1);
      base = base + 2'd2;
    end
    foreach (node_idx[i]) load_entry(node_idx[i], node_val[i], 1'b1);
    foreach (slot_q[i]) load_entry(slot_q[i], VAL_W'($urandom), 1'b0);
  endtask

  initial begin
    int start, pick, leaves;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // root is a leaf: every bit emits it, bit count zero and saturation
    load_entry(10'd0, 16'h8000, 1'b0);
    decode_word(16'hFFFF, 5'd16);
    decode_word(16'h0000, 5'd0);
    decode_word(16'h1234, 5'd31);
    decode_word(16'h0000, 5'd17);
    // root children wrap to 1023 and back to the root
    load_entry(10'd1023, 16'h0402, 1'b1);
    load_entry(10'd2, 16'h7FFF, 1'b0);
    load_entry(10'd3, 16'hFFFF, 1'b0);
    load_entry(10'd0, 16'hFFFF, 1'b1);
    decode_word(16'h8000, 5'd1);
    decode_word(16'h0000, 5'd1);
    decode_word(16'h4000, 5'd3);
    // node under the walk turned into a leaf mid code
    load_entry(10'd1023, 16'h1234, 1'b0);
    decode_word(16'hFFFF, 5'd2);
    load_entry(10'd1023, 16'h0402, 1'b1);
    decode_word(16'h0000, 5'd16);
    decode_word(16'h5555, 5'd16);
    load_entry(10'd2, 16'h0000, 1'b0);
    decode_word(16'h0000, 5'd2);
    wait_drained();

    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      idle_on = $urandom_range(0, 3) != 0;
      pick = $urandom_range(0, 9);
      leaves = (pick == 0) ? 1 : (pick == 1) ? 16 : $urandom_range(2, 10);
      build_tree(leaves);
      repeat ($urandom_range(6, 20)) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          if (have_pair && $urandom_range(0, 1))
            load_entry(IDX_W'($urandom), {(VAL_W-IDX_W)'($urandom), pair_base}, 1'b1);
          else
            load_entry(IDX_W'($urandom), VAL_W'($urandom), 1'b0);
        end else if (pick == 1) begin
          wait_drained();
        end else if (pick == 2) begin
          decode_word(WORD_W'($urandom), CNT_W'($urandom_range(0, 31)));
        end else begin
          decode_word(WORD_W'($urandom), CNT_W'($urandom_range(1, 16)));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hutw_pkg.sv
src/hutw_front.sv
src/hutw_back.sv
src/huffman_table_walk_decoder_unit.sv
src/hutw_checker.sv
bench/testbench.sv
